FILE: hw/rtl/bhtm_pkg.sv
// ----------------------------------------------------------------------------
// bhtm_pkg
// Shared constants and template tables for the binary hole template matcher.
// ----------------------------------------------------------------------------
package bhtm_pkg;

    localparam int ROW_BITS    = 32;
    localparam int HIST_DEPTH  = 4;
    localparam int NUM_TMPL    = 5;
    localparam int MAX_T_ROWS  = 5;
    localparam int MAX_T_COLS  = 5;
    localparam int CFG_W       = 6;
    localparam int SEEN_W      = 3;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(12);

    // template rows, column 0 at bit 31
    localparam int TMPL_H [NUM_TMPL] = '{3, 3, 3, 4, 5};
    localparam int TMPL_W [NUM_TMPL] = '{3, 4, 5, 3, 3};

    localparam logic [31:0] TMPL_PAT [NUM_TMPL][MAX_T_ROWS] = '{
        '{32'h4000_0000, 32'hA000_0000, 32'h4000_0000, 32'h0, 32'h0},
        '{32'h6000_0000, 32'h9000_0000, 32'h6000_0000, 32'h0, 32'h0},
        '{32'h7000_0000, 32'h8800_0000, 32'h7000_0000, 32'h0, 32'h0},
        '{32'h4000_0000, 32'hA000_0000, 32'hA000_0000, 32'h4000_0000, 32'h0},
        '{32'h4000_0000, 32'hA000_0000, 32'hA000_0000, 32'hA000_0000,
          32'h4000_0000}
    };

    localparam logic [31:0] TMPL_MSK [NUM_TMPL][MAX_T_ROWS] = '{
        '{32'h4000_0000, 32'hE000_0000, 32'h4000_0000, 32'h0, 32'h0},
        '{32'h6000_0000, 32'hF000_0000, 32'h6000_0000, 32'h0, 32'h0},
        '{32'h7000_0000, 32'hF800_0000, 32'h7000_0000, 32'h0, 32'h0},
        '{32'h4000_0000, 32'hE000_0000, 32'hE000_0000, 32'h4000_0000, 32'h0},
        '{32'h4000_0000, 32'hE000_0000, 32'hE000_0000, 32'hE000_0000,
          32'h4000_0000}
    };

endpackage

FILE: hw/rtl/bhtm_if.sv
// ----------------------------------------------------------------------------
// bhtm interfaces
// Row input, result output and width configuration channels.
// ----------------------------------------------------------------------------
interface bhtm_row_if #(
    parameter int ROW_BITS = bhtm_pkg::ROW_BITS
);
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] row_bits;
    logic                last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface bhtm_res_if;
    logic valid;
    logic ready;
    logic hit_now;
    logic hit_in_frame;
    logic frame_done;

    modport source (output valid, output hit_now, output hit_in_frame,
                    output frame_done, input ready);
    modport sink   (input valid, input hit_now, input hit_in_frame,
                    input frame_done, output ready);
endinterface

interface bhtm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bhtm_pkg::CFG_W-1:0]  image_width;

    modport source (output valid, output image_width, input ready);
    modport sink   (input valid, input image_width, output ready);
endinterface

FILE: hw/rtl/bhtm_match.sv
// ----------------------------------------------------------------------------
// bhtm_match
// Checks all templates at all column offsets of a five-row window in parallel.
// ----------------------------------------------------------------------------
module bhtm_match #(
    parameter int ROW_BITS = bhtm_pkg::ROW_BITS
) (
    input  logic [ROW_BITS-1:0]               i_win [bhtm_pkg::MAX_T_ROWS],
    input  logic [bhtm_pkg::SEEN_W-1:0]       i_rows_seen,
    input  logic [bhtm_pkg::CFG_W-1:0]        i_width,
    output logic                              o_hit
);

    localparam int NT = bhtm_pkg::NUM_TMPL;
    localparam int MR = bhtm_pkg::MAX_T_ROWS;
    localparam int XW = $clog2(ROW_BITS + 1) > bhtm_pkg::CFG_W ?
                        $clog2(ROW_BITS + 1) : bhtm_pkg::CFG_W;

    logic [ROW_BITS-1:0] hit_x [NT];
    logic [NT-1:0]       hit_t;

    for (genvar t = 0; t < NT; t++) begin : g_tmpl
        localparam int H = bhtm_pkg::TMPL_H[t];
        localparam int W = bhtm_pkg::TMPL_W[t];

        logic tall_ok;
        assign tall_ok = i_rows_seen >= bhtm_pkg::SEEN_W'(H - 1);

        for (genvar x = 0; x < ROW_BITS; x++) begin : g_off
            if (x + W <= ROW_BITS) begin : g_fit
                logic ok;
                always_comb begin
                    ok = 1'b1;
                    for (int r = 0; r < H; r++) begin
                        for (int c = 0; c < W; c++) begin
                            if (bhtm_pkg::TMPL_MSK[t][r][31-c]) begin
                                if (i_win[MR-H+r][ROW_BITS-1-x-c] !=
                                    bhtm_pkg::TMPL_PAT[t][r][31-c]) begin
                                    ok = 1'b0;
                                end
                            end
                        end
                    end
                end
                assign hit_x[t][x] = ok && tall_ok &&
                                     (XW'(i_width) >= XW'(x + W));
            end else begin : g_nofit
                assign hit_x[t][x] = 1'b0;
            end
        end

        assign hit_t[t] = |hit_x[t];
    end

    assign o_hit = |hit_t;

endmodule

FILE: hw/rtl/binary_hole_template_matcher_core.sv
// ----------------------------------------------------------------------------
// binary_hole_template_matcher_core
// Hit-or-miss search for enclosed empty cells and short empty runs over the
// last rows of a binary image, with a per-row and a per-frame hit flag.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                | beat
//  i_row   | in  | row_bits, last_row                     | one image row
//  o_res   | out | hit_now, hit_in_frame, frame_done      | one result per row
//  i_cfg   | in  | image_width                            | register write
//
//  one row per cycle sustained while o_res is ready; each result is registered
//  after its row beat (input register, then match logic into the result register)
//  reset clears history, row count, sticky flag and sets image_width to 12
//  a stalled o_res holds its beat while the input register still takes one row
// ----------------------------------------------------------------------------
module binary_hole_template_matcher_core #(
    parameter int ROW_BITS = bhtm_pkg::ROW_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bhtm_row_if.sink      i_row,
    bhtm_res_if.source    o_res,
    bhtm_cfg_if.sink      i_cfg
);

    localparam int HD = bhtm_pkg::HIST_DEPTH;
    localparam int MR = bhtm_pkg::MAX_T_ROWS;
    localparam int SW = bhtm_pkg::SEEN_W;

    logic                          r_in_valid;
    logic [ROW_BITS-1:0]           r_in_row;
    logic                          r_in_last;

    logic                          r_out_valid;
    logic                          r_hit_now;
    logic                          r_hit_frame;
    logic                          r_done;

    logic [ROW_BITS-1:0]           r_hist [HD];
    logic [SW-1:0]                 r_rows_seen;
    logic                          r_sticky;
    logic [bhtm_pkg::CFG_W-1:0]    r_width;

    logic                          advance;
    logic                          hit;
    logic [ROW_BITS-1:0]           win [MR];

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_row.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // oldest row first, current row last
    always_comb begin
        for (int i = 0; i < HD; i++) begin
            win[HD-1-i] = r_hist[i];
        end
        win[MR-1] = r_in_row;
    end

    bhtm_match #(
        .ROW_BITS (ROW_BITS)
    ) u_match (
        .i_win       (win),
        .i_rows_seen (r_rows_seen),
        .i_width     (r_width),
        .o_hit       (hit)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_row.ready) begin
            r_in_valid <= i_row.valid;
        end
        if (i_row.valid && i_row.ready) begin
            r_in_row  <= i_row.row_bits;
            r_in_last <= i_row.last_row;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_hit_now   <= hit;
            r_hit_frame <= r_sticky | hit;
            r_done      <= r_in_last;
        end
    end

    // frame history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HD; i++) begin
                r_hist[i] <= '0;
            end
            r_rows_seen <= '0;
            r_sticky    <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                for (int i = 0; i < HD; i++) begin
                    r_hist[i] <= '0;
                end
                r_rows_seen <= '0;
                r_sticky    <= 1'b0;
            end else begin
                for (int i = HD - 1; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= r_in_row;
                if (r_rows_seen < SW'(HD)) begin
                    r_rows_seen <= r_rows_seen + SW'(1);
                end
                r_sticky <= r_sticky | hit;
            end
        end
    end

    // width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= bhtm_pkg::WIDTH_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_width <= i_cfg.image_width;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.hit_now      = r_hit_now;
    assign o_res.hit_in_frame = r_hit_frame;
    assign o_res.frame_done   = r_done;

endmodule
